[sv/first_fit_free_list_allocator_unit_macros.svh]
// assertion macros for the first-fit allocator
// no dependencies; included by the top level only
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ffa_pkg.sv]
// shared types, codes and defaults for the first-fit allocator
// no dependencies
package ffa_pkg;

    localparam int REQ_SIZE_W = 12;
    localparam int ADDR_W     = 10;

    localparam int HEAP_BYTES_DEF   = 1024;
    localparam int WORD_BYTES_DEF   = 8;
    localparam int HEADER_BYTES_DEF = 16;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SIZE_ZERO  = 2'd1,
        ST_SIZE_ALIGN = 2'd2,
        ST_NO_FIT     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [REQ_SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0]     block_addr;
    } t_in_beat;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        t_status           status;
    } t_out_beat;

    typedef struct packed {
        logic re;
        logic we_size;
        logic we_next;
    } t_ram_ctl;

endpackage

[sv/ffa_hdr_ram.sv]
// header store: payload size and next link per heap byte offset
// uses ffa_pkg for the control struct
module ffa_hdr_ram #(
    parameter int DEPTH = ffa_pkg::HEAP_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  ffa_pkg::t_ram_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  logic [LW-1:0]     i_size,
    input  logic [LW-1:0]     i_next,
    output logic [LW-1:0]     o_size,
    output logic [LW-1:0]     o_next
);

    logic [LW-1:0] mem_size [DEPTH];
    logic [LW-1:0] mem_next [DEPTH];
    logic [LW-1:0] r_size;
    logic [LW-1:0] r_next;

    // separate field enables so a free can rewrite the link alone
    always_ff @(posedge i_clk) begin
        if (i_ctl.we_size) begin
            mem_size[i_addr] <= i_size;
        end
        if (i_ctl.we_next) begin
            mem_next[i_addr] <= i_next;
        end
        if (i_ctl.re) begin
            r_size <= mem_size[i_addr];
            r_next <= mem_next[i_addr];
        end
    end

    assign o_size = r_size;
    assign o_next = r_next;

endmodule

[sv/ffa_rem_unit.sv]
// iterative remainder unit, one restoring step per cycle
// uses ffa_pkg for the operand width
module ffa_rem_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ffa_pkg::REQ_SIZE_W-1:0] i_dividend,
    input  logic [ffa_pkg::REQ_SIZE_W-1:0] i_divisor,
    output logic                           o_done,
    output logic                           o_rem_zero
);

    localparam int W  = ffa_pkg::REQ_SIZE_W;
    localparam int CNW = $clog2(W);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [W-1:0]   r_dvd;
    logic [W-1:0]   r_div;
    logic [W-1:0]   r_rem;
    logic [W:0]     w_trial;
    logic [W:0]     w_diff;

    always_comb begin
        w_trial = {r_rem, r_dvd[W-1]};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[W-2:0], 1'b0};
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= w_diff[W-1:0];
                end else begin
                    r_rem <= w_trial[W-1:0];
                end
                if (r_cnt == CNW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

[sv/first_fit_free_list_allocator_unit.sv]
// first-fit allocator top: request sequencer over ffa_hdr_ram and ffa_rem_unit, uses ffa_pkg
// init, free and unknown requests: the taken beat passes S_EXEC, then S_EMIT registers the result
// alloc: S_CHECK for the size check unless size is zero or the word, S_READ and S_EVAL per header
// walked (one header store read each), S_SPLIT1/2 to split; next beat taken once the result is out
// reset clears the sequencer and empties the list; the header store itself is not cleared
module first_fit_free_list_allocator_unit #(
    parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
    parameter int WORD_BYTES   = ffa_pkg::WORD_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ffa_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ffa_pkg::t_out_beat o_out_beat
);

    `include "first_fit_free_list_allocator_unit_macros.svh"

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int LW = $clog2(HEAP_BYTES + 1);
    localparam int SW = ffa_pkg::REQ_SIZE_W;
    localparam int CW = ((LW > SW) ? LW : SW) + 2;

    localparam logic [LW-1:0] END_L   = LW'(HEAP_BYTES);
    localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] SPLIT_C = CW'(HEADER_BYTES + WORD_BYTES);
    localparam logic [SW-1:0] WORD_S  = SW'(WORD_BYTES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_SPLIT1,
        S_SPLIT2,
        S_RELINK,
        S_EMIT
    } t_state;

    t_state             r_state;
    ffa_pkg::t_in_beat  r_req;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_cur;
    logic [LW-1:0]      r_prev;
    logic               r_has_prev;
    logic [LW-1:0]      r_steps;
    logic [SW-1:0]      r_need;
    logic [LW-1:0]      r_link;
    logic [LW-1:0]      r_cnext;
    logic [LW-1:0]      r_nsz;
    logic [LW-1:0]      r_res_addr;
    ffa_pkg::t_status   r_res_status;
    logic               r_out_valid;
    ffa_pkg::t_out_beat r_out_beat;

    ffa_pkg::t_ram_ctl  w_ctl;
    logic [AW-1:0]      w_addr;
    logic [LW-1:0]      w_wsize;
    logic [LW-1:0]      w_wnext;
    logic [LW-1:0]      w_rsize;
    logic [LW-1:0]      w_rnext;

    logic               w_rem_start;
    logic [SW-1:0]      w_dividend;
    logic [SW-1:0]      w_divisor;
    logic               w_rem_done;
    logic               w_rem_zero;

    logic [CW-1:0]      w_size_c;
    logic [CW-1:0]      w_hs;
    logic [CW-1:0]      w_baddr_c;
    logic [CW-1:0]      w_csz;
    logic [CW-1:0]      w_need_c;
    logic [CW-1:0]      w_nb;
    logic [CW-1:0]      w_res_c;

    ffa_hdr_ram #(
        .DEPTH (HEAP_BYTES),
        .AW    (AW),
        .LW    (LW)
    ) u_hdr_ram (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_addr (w_addr),
        .i_size (w_wsize),
        .i_next (w_wnext),
        .o_size (w_rsize),
        .o_next (w_rnext)
    );

    ffa_rem_unit u_rem_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_rem_done),
        .o_rem_zero (w_rem_zero)
    );

    always_comb begin
        w_size_c  = CW'(r_req.req_size);
        w_hs      = (w_size_c > HEAP_C) ? HEAP_C : w_size_c;
        w_baddr_c = CW'(r_req.block_addr);
        w_csz     = CW'(w_rsize);
        w_need_c  = CW'(r_need);
        w_nb      = CW'(r_cur) + HDR_C + w_need_c;
        w_res_c   = CW'(r_res_addr);

        // size checked against the word: larger sizes divide by it, smaller ones into it
        w_rem_start = (r_state == S_EXEC) && (r_req.req_type == ffa_pkg::REQ_ALLOC) &&
                      (r_req.req_size != '0) && (r_req.req_size != WORD_S);
        if (r_req.req_size > WORD_S) begin
            w_dividend = r_req.req_size;
            w_divisor  = WORD_S;
        end else begin
            w_dividend = WORD_S;
            w_divisor  = r_req.req_size;
        end

        w_ctl   = '0;
        w_addr  = r_cur[AW-1:0];
        w_wsize = r_nsz;
        w_wnext = r_cnext;
        unique case (r_state)
            S_EXEC: begin
                if (r_req.req_type == ffa_pkg::REQ_INIT && w_hs >= HDR_C) begin
                    w_ctl.we_size = 1'b1;
                    w_ctl.we_next = 1'b1;
                    w_addr        = '0;
                    w_wsize       = LW'(w_hs - HDR_C);
                    w_wnext       = END_L;
                end else if (r_req.req_type == ffa_pkg::REQ_FREE && w_baddr_c < HEAP_C) begin
                    w_ctl.we_next = 1'b1;
                    w_addr        = AW'(r_req.block_addr);
                    w_wnext       = r_head;
                end
            end
            S_READ: begin
                w_ctl.re = (r_cur < END_L) && (r_steps < END_L);
            end
            S_SPLIT1: begin
                // new remainder header, dropped when it falls outside the heap
                w_ctl.we_size = (r_link < END_L);
                w_ctl.we_next = (r_link < END_L);
                w_addr        = r_link[AW-1:0];
            end
            S_SPLIT2: begin
                w_ctl.we_size = 1'b1;
                w_wsize       = LW'(r_need);
            end
            S_RELINK: begin
                w_ctl.we_next = r_has_prev;
                w_addr        = r_prev[AW-1:0];
                w_wnext       = r_link;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= END_L;
            r_out_valid <= 1'b0;
            r_has_prev  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req        <= i_in_beat;
                        r_res_addr   <= '0;
                        r_res_status <= ffa_pkg::ST_OK;
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_EMIT;
                    unique case (r_req.req_type)
                        ffa_pkg::REQ_INIT: begin
                            r_head <= (w_hs >= HDR_C) ? '0 : END_L;
                        end
                        ffa_pkg::REQ_FREE: begin
                            r_res_addr <= LW'(w_baddr_c);
                            if (w_baddr_c < HEAP_C) begin
                                r_head <= LW'(w_baddr_c);
                            end
                        end
                        ffa_pkg::REQ_ALLOC: begin
                            r_need     <= (r_req.req_size > WORD_S) ? r_req.req_size : WORD_S;
                            r_cur      <= r_head;
                            r_has_prev <= 1'b0;
                            r_steps    <= '0;
                            if (r_req.req_size == '0) begin
                                r_res_status <= ffa_pkg::ST_SIZE_ZERO;
                            end else if (w_rem_start) begin
                                r_state <= S_CHECK;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_CHECK: begin
                    if (w_rem_done) begin
                        if (w_rem_zero) begin
                            r_state <= S_READ;
                        end else begin
                            r_res_status <= ffa_pkg::ST_SIZE_ALIGN;
                            r_state      <= S_EMIT;
                        end
                    end
                end
                S_READ: begin
                    if (r_cur >= END_L || r_steps >= END_L) begin
                        r_res_status <= ffa_pkg::ST_NO_FIT;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_csz >= w_need_c) begin
                        r_res_addr <= r_cur;
                        if (w_csz >= w_need_c + SPLIT_C) begin
                            // remainder link saturates to end of list past the heap
                            r_link  <= (w_nb >= HEAP_C) ? END_L : LW'(w_nb);
                            r_nsz   <= LW'(w_csz - w_need_c - HDR_C);
                            r_cnext <= w_rnext;
                            r_state <= S_SPLIT1;
                        end else begin
                            r_link  <= w_rnext;
                            r_state <= S_RELINK;
                        end
                    end else begin
                        r_prev     <= r_cur;
                        r_has_prev <= 1'b1;
                        r_cur      <= w_rnext;
                        r_steps    <= r_steps + 1'b1;
                        r_state    <= S_READ;
                    end
                end
                S_SPLIT1: begin
                    r_state <= S_SPLIT2;
                end
                S_SPLIT2: begin
                    r_state <= S_RELINK;
                end
                S_RELINK: begin
                    if (!r_has_prev) begin
                        r_head <= r_link;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid            <= 1'b1;
                        r_out_beat.result_addr <= w_res_c[ffa_pkg::ADDR_W-1:0];
                        r_out_beat.status      <= r_res_status;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `FFA_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "allocator took a beat without going busy")
    `FFA_ASSERT_IMP(a_eval_in_heap, i_clk, i_rst_n, r_state == S_EVAL,
        (r_cur < END_L) && (r_steps < END_L), "header evaluated outside heap or walk limit")
    `FFA_ASSERT_IMP(a_rem_done_in_check, i_clk, i_rst_n, w_rem_done,
        r_state == S_CHECK, "size check finished outside the check state")

endmodule
